// ----- rtl/core/bbc_pkg.sv -----
package bbc_pkg;

    // Field widths fixed by the stream format
    localparam int LBA_W    = 32;
    localparam int BUF_W    = 6;
    localparam int STATUS_W = 3;
    localparam int TDATA_W  = 40;

    // Default pool size
    localparam int DEF_NUM_BUFFERS = 64;

    // Request kinds
    localparam logic OP_GET     = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_HIT    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FRESH  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EVICT  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NONE   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_APPEND = 3'd4;
    localparam logic [STATUS_W-1:0] ST_QUEUED = 3'd5;

    typedef struct packed {
        logic             op;
        logic [LBA_W-1:0] lba;
        logic [BUF_W-1:0] buf_idx;
    } t_request;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [BUF_W-1:0]    buffer_out;
        logic [LBA_W-1:0]    old_lba;
    } t_result;

endpackage

// ----- rtl/core/bbc_ram.sv -----
// Simple dual-port RAM: one write port, one read port, registered read data
module bbc_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/bbc_ctrl.sv -----
// Request sequencer: queue pointers, pipelined walk of the used queue,
// allocation and eviction
module bbc_ctrl #(
    parameter int NUM_BUFFERS = bbc_pkg::DEF_NUM_BUFFERS,
    parameter int IDX_W       = $clog2(NUM_BUFFERS)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // request side
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  bbc_pkg::t_request i_req,
    // result side
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output bbc_pkg::t_result  o_res,
    // tag memory
    output logic              o_tag_we,
    output logic [IDX_W-1:0]  o_tag_waddr,
    output logic [bbc_pkg::LBA_W-1:0] o_tag_wdata,
    output logic [IDX_W-1:0]  o_tag_raddr,
    input  logic [bbc_pkg::LBA_W-1:0] i_tag_rdata,
    // used-queue memory
    output logic              o_q_we,
    output logic [IDX_W-1:0]  o_q_waddr,
    output logic [IDX_W-1:0]  o_q_wdata,
    output logic [IDX_W-1:0]  o_q_raddr,
    input  logic [IDX_W-1:0]  i_q_rdata
);

    import bbc_pkg::*;

    localparam int CNT_W = $clog2(NUM_BUFFERS + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RTAG = 3'd1;
    localparam logic [2:0] S_WALK = 3'd2;
    localparam logic [2:0] S_EVQ  = 3'd3;
    localparam logic [2:0] S_EVT  = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    // control state
    logic [2:0]       r_state, n_state;
    logic [IDX_W-1:0] r_head, n_head;
    logic [IDX_W-1:0] r_tail, n_tail;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_next_unused, n_next_unused;
    logic             r_va, n_va;
    logic             r_vb, n_vb;

    // payload
    t_request         r_req, n_req;
    logic [LBA_W-1:0] r_key, n_key;
    logic [IDX_W-1:0] r_p, n_p;
    logic [CNT_W-1:0] r_issued, n_issued;
    logic [IDX_W-1:0] r_bb, n_bb;
    t_result          r_res, n_res;

    logic             issue;

    function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] p);
        logic [IDX_W-1:0] q;
        q = (p == IDX_W'(NUM_BUFFERS - 1)) ? '0 : p + 1'b1;
        return q;
    endfunction

    // Next-state logic
    always_comb begin
        n_state       = r_state;
        n_head        = r_head;
        n_tail        = r_tail;
        n_count       = r_count;
        n_next_unused = r_next_unused;
        n_va          = 1'b0;
        n_vb          = 1'b0;
        n_req         = r_req;
        n_key         = r_key;
        n_p           = r_p;
        n_issued      = r_issued;
        n_bb          = r_bb;
        n_res         = r_res;

        o_tag_we    = 1'b0;
        o_tag_waddr = r_bb;
        o_tag_wdata = r_req.lba;
        o_tag_raddr = i_q_rdata;
        o_q_we      = 1'b0;
        o_q_waddr   = r_tail;
        o_q_wdata   = IDX_W'(r_req.buf_idx);
        o_q_raddr   = r_p;
        o_in_ready  = 1'b0;
        o_res_valid = 1'b0;
        issue       = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                // nothing is taken while reset is held
                o_in_ready  = i_rst_n;
                // release looks up the tag of its buffer first
                o_tag_raddr = IDX_W'(i_req.buf_idx);
                if (i_in_valid) begin
                    n_req    = i_req;
                    n_p      = r_head;
                    n_issued = '0;
                    if (i_req.op == OP_GET) begin
                        n_key   = i_req.lba;
                        n_state = S_WALK;
                    end else if (32'(i_req.buf_idx) >= 32'(NUM_BUFFERS) ||
                                 r_count == CNT_W'(NUM_BUFFERS)) begin
                        n_res   = '{status: ST_QUEUED, buffer_out: i_req.buf_idx,
                                    old_lba: '0};
                        n_state = S_DONE;
                    end else begin
                        n_state = S_RTAG;
                    end
                end
            end

            S_RTAG: begin
                n_key   = i_tag_rdata;
                n_state = S_WALK;
            end

            // Three-deep walk: queue read, tag read, compare; one entry a cycle
            S_WALK: begin
                issue = (r_issued < r_count);
                if (issue) begin
                    n_va     = 1'b1;
                    n_issued = r_issued + 1'b1;
                    n_p      = wrap_inc(r_p);
                end
                if (r_va) begin
                    n_vb = 1'b1;
                    n_bb = i_q_rdata;
                end
                if (r_vb && i_tag_rdata == r_key) begin
                    n_va = 1'b0;
                    n_vb = 1'b0;
                    if (r_req.op == OP_GET) begin
                        n_res = '{status: ST_HIT, buffer_out: BUF_W'(r_bb), old_lba: '0};
                    end else begin
                        n_res = '{status: ST_QUEUED, buffer_out: r_req.buf_idx,
                                  old_lba: '0};
                    end
                    n_state = S_DONE;
                end else if (!issue && !r_va && !r_vb) begin
                    // walk exhausted: miss
                    if (r_req.op == OP_RELEASE) begin
                        o_q_we  = 1'b1;
                        n_tail  = wrap_inc(r_tail);
                        n_count = r_count + 1'b1;
                        n_res   = '{status: ST_APPEND, buffer_out: r_req.buf_idx,
                                    old_lba: '0};
                        n_state = S_DONE;
                    end else if (r_next_unused < CNT_W'(NUM_BUFFERS)) begin
                        o_tag_we      = 1'b1;
                        o_tag_waddr   = IDX_W'(r_next_unused);
                        n_next_unused = r_next_unused + 1'b1;
                        n_res         = '{status: ST_FRESH,
                                          buffer_out: BUF_W'(r_next_unused),
                                          old_lba: '0};
                        n_state       = S_DONE;
                    end else if (r_count != '0) begin
                        o_q_raddr = r_head;
                        n_state   = S_EVQ;
                    end else begin
                        n_res   = '{status: ST_NONE, buffer_out: '0, old_lba: '0};
                        n_state = S_DONE;
                    end
                end
            end

            // pop the head and fetch its old tag
            S_EVQ: begin
                o_tag_raddr = i_q_rdata;
                n_bb        = i_q_rdata;
                n_head      = wrap_inc(r_head);
                n_count     = r_count - 1'b1;
                n_state     = S_EVT;
            end

            S_EVT: begin
                o_tag_we = 1'b1;
                n_res    = '{status: ST_EVICT, buffer_out: BUF_W'(r_bb),
                             old_lba: i_tag_rdata};
                n_state  = S_DONE;
            end

            S_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_head        <= '0;
            r_tail        <= '0;
            r_count       <= '0;
            r_next_unused <= '0;
            r_va          <= 1'b0;
            r_vb          <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_head        <= n_head;
            r_tail        <= n_tail;
            r_count       <= n_count;
            r_next_unused <= n_next_unused;
            r_va          <= n_va;
            r_vb          <= n_vb;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_req    <= n_req;
        r_key    <= n_key;
        r_p      <= n_p;
        r_issued <= n_issued;
        r_bb     <= n_bb;
        r_res    <= n_res;
    end

    assign o_res = r_res;

endmodule

// ----- rtl/core/block_buffer_cache_lookup.sv -----
// Block buffer cache lookup over a pool of NUM_BUFFERS buffers. Each request
// is one transaction in and one transaction out. A get walks the used queue
// oldest first, one entry per cycle through a three-deep read/compare
// pipeline over the queue and tag memories; an eviction adds a head pop and
// an old-tag read. A release first reads its buffer's tag and then walks the
// queue the same way; an out-of-pool index or a full queue answers without
// a walk. One request is in flight at a time; a new one is taken while the
// previous result still waits in the output register. Tags and queue
// entries live in RAM with no reset; a release of a buffer not yet handed
// out reads its unwritten tag.
module block_buffer_cache_lookup #(
    parameter int NUM_BUFFERS = bbc_pkg::DEF_NUM_BUFFERS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [bbc_pkg::TDATA_W-1:0]   s_axis_tdata,   // lba[31:0], buffer[37:32]
    input  logic                          s_axis_tuser,   // op
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [bbc_pkg::TDATA_W-1:0]   m_axis_tdata,   // buffer_out[5:0], old_lba[37:6]
    output logic [bbc_pkg::STATUS_W-1:0]  m_axis_tuser    // status
);

    import bbc_pkg::*;

    localparam int IDX_W = $clog2(NUM_BUFFERS);

    t_request         req;
    t_result          res;
    logic             res_valid;
    logic             res_ready;

    logic             tag_we;
    logic [IDX_W-1:0] tag_waddr;
    logic [LBA_W-1:0] tag_wdata;
    logic [IDX_W-1:0] tag_raddr;
    logic [LBA_W-1:0] tag_rdata;
    logic             q_we;
    logic [IDX_W-1:0] q_waddr;
    logic [IDX_W-1:0] q_wdata;
    logic [IDX_W-1:0] q_raddr;
    logic [IDX_W-1:0] q_rdata;

    logic             r_out_valid;
    t_result          r_out;

    // Unpack the request
    assign req.op      = s_axis_tuser;
    assign req.lba     = s_axis_tdata[LBA_W-1:0];
    assign req.buf_idx = s_axis_tdata[LBA_W +: BUF_W];

    bbc_ctrl #(
        .NUM_BUFFERS (NUM_BUFFERS),
        .IDX_W       (IDX_W)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_req       (req),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res),
        .o_tag_we    (tag_we),
        .o_tag_waddr (tag_waddr),
        .o_tag_wdata (tag_wdata),
        .o_tag_raddr (tag_raddr),
        .i_tag_rdata (tag_rdata),
        .o_q_we      (q_we),
        .o_q_waddr   (q_waddr),
        .o_q_wdata   (q_wdata),
        .o_q_raddr   (q_raddr),
        .i_q_rdata   (q_rdata)
    );

    // Tag per buffer
    bbc_ram #(
        .WIDTH  (LBA_W),
        .DEPTH  (NUM_BUFFERS),
        .ADDR_W (IDX_W)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (tag_we),
        .i_waddr (tag_waddr),
        .i_wdata (tag_wdata),
        .i_raddr (tag_raddr),
        .o_rdata (tag_rdata)
    );

    // Circular used queue of buffer indices
    bbc_ram #(
        .WIDTH  (IDX_W),
        .DEPTH  (NUM_BUFFERS),
        .ADDR_W (IDX_W)
    ) u_queue_ram (
        .i_clk   (i_clk),
        .i_we    (q_we),
        .i_waddr (q_waddr),
        .i_wdata (q_wdata),
        .i_raddr (q_raddr),
        .o_rdata (q_rdata)
    );

    // Output register: frees the sequencer while a result waits
    assign res_ready = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.status;
    assign m_axis_tdata  = {(TDATA_W - BUF_W - LBA_W)'(0), r_out.old_lba, r_out.buffer_out};

endmodule

// ----- test/block_buffer_cache_lookup_tb.sv -----
`timescale 1ns / 100ps

module block_buffer_cache_lookup_tb;
    import bbc_pkg::*;

    localparam int POOL = DEF_NUM_BUFFERS;

    // Mirror of the cache state plus the results still owed by the block
    class lookup_scoreboard;
        logic [LBA_W-1:0] buffer_tag [POOL];
        int               fifo_entry [POOL];
        int               next_unused = 0;
        int               head = 0;
        int               tail = 0;
        int               queued = 0;
        t_result          awaited_results [$];
        int               mismatches = 0;
        int               status_seen [6];

        // Oldest-first walk of the used queue; -1 when no queued buffer holds the tag
        function int find_queued_tag(logic [LBA_W-1:0] tag);
            int p;
            p = head;
            for (int n = 0; n < queued; n++) begin
                if (buffer_tag[fifo_entry[p]] == tag) begin
                    return fifo_entry[p];
                end
                p = (p + 1) % POOL;
            end
            return -1;
        endfunction

        // Work out the answer to one accepted request and advance the state
        function void note_request(logic op, logic [LBA_W-1:0] lba, logic [BUF_W-1:0] idx);
            t_result r;
            int      found;
            int      b;
            r = '0;
            if (op == OP_GET) begin
                found = find_queued_tag(lba);
                if (found >= 0) begin
                    r.status     = ST_HIT;
                    r.buffer_out = BUF_W'(found);
                end else if (next_unused < POOL) begin
                    r.status     = ST_FRESH;
                    r.buffer_out = BUF_W'(next_unused);
                    buffer_tag[next_unused] = lba;
                    next_unused++;
                end else if (queued > 0) begin
                    // pop the oldest entry and retag it
                    b            = fifo_entry[head];
                    head         = (head + 1) % POOL;
                    queued--;
                    r.status     = ST_EVICT;
                    r.buffer_out = BUF_W'(b);
                    r.old_lba    = buffer_tag[b];
                    buffer_tag[b] = lba;
                end else begin
                    r.status = ST_NONE;
                end
            end else begin
                r.buffer_out = idx;
                if (int'(idx) >= POOL || queued >= POOL ||
                    find_queued_tag(buffer_tag[int'(idx) % POOL]) >= 0) begin
                    r.status = ST_QUEUED;
                end else begin
                    fifo_entry[tail] = int'(idx);
                    tail             = (tail + 1) % POOL;
                    queued++;
                    r.status         = ST_APPEND;
                end
            end
            awaited_results.push_back(r);
        endfunction

        // Compare one result transaction with the oldest awaited result
        function void check_result(logic [STATUS_W-1:0] status, logic [BUF_W-1:0] buf_out,
                                   logic [LBA_W-1:0] old_lba);
            t_result exp;
            if (awaited_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: unexpected result status %0d buffer %0d old_lba %h",
                             $time, status, buf_out, old_lba);
                end
                return;
            end
            exp = awaited_results.pop_front();
            if (exp.status < 6) begin
                status_seen[exp.status]++;
            end
            if (status !== exp.status || buf_out !== exp.buffer_out ||
                old_lba !== exp.old_lba) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: mismatch exp status %0d buffer %0d old_lba %h", $time,
                             exp.status, exp.buffer_out, exp.old_lba);
                    $display("%0t:          got status %0d buffer %0d old_lba %h", $time,
                             status, buf_out, old_lba);
                end
            end
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [TDATA_W-1:0]  s_axis_tdata = '0;   // lba[31:0], buffer[37:32]
    logic                s_axis_tuser = 1'b0; // op
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [TDATA_W-1:0]  m_axis_tdata;        // buffer_out[5:0], old_lba[37:6]
    logic [STATUS_W-1:0] m_axis_tuser;        // status

    lookup_scoreboard sb = new();
    bit               quiet = 1'b0;   // no idling on either side while set
    int               issued = 0;

    block_buffer_cache_lookup #(
        .NUM_BUFFERS(POOL)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #1 i_clk = ~i_clk;

    // Result side back-pressure
    always @(negedge i_clk) begin
        m_axis_tready <= quiet || ($urandom_range(0, 99) >= 7);
    end

    // Result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_result(m_axis_tuser, m_axis_tdata[BUF_W-1:0],
                            m_axis_tdata[BUF_W +: LBA_W]);
        end
    end

    // Drive one request transaction and wait for its acceptance
    task automatic issue_request(input logic op, input logic [LBA_W-1:0] addr,
                                 input logic [BUF_W-1:0] idx);
        @(negedge i_clk);
        while (!quiet && $urandom_range(0, 99) < 7) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, idx, addr};
        s_axis_tuser  <= op;
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
        sb.note_request(op, addr, idx);
        issued++;
    endtask

    initial begin
        int unsigned      pick;
        logic [LBA_W-1:0] addr;
        int               order [POOL];
        int               t;
        int               k;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extreme tags, duplicate tags, hits and repeated releases
        issue_request(OP_GET, 32'h0000_0000, 6'd63);
        issue_request(OP_GET, 32'hFFFF_FFFF, 6'd0);
        issue_request(OP_GET, 32'h0000_0000, 6'd21);     // miss: tag not queued yet
        issue_request(OP_RELEASE, 32'hFFFF_FFFF, 6'd0);
        issue_request(OP_RELEASE, 32'h0000_0000, 6'd0);  // same buffer again
        issue_request(OP_RELEASE, 32'h1234_5678, 6'd2);  // another buffer, same tag
        issue_request(OP_GET, 32'h0000_0000, 6'd42);     // hit
        issue_request(OP_RELEASE, 32'h0000_0000, 6'd1);
        issue_request(OP_GET, 32'hFFFF_FFFF, 6'd0);      // hit
        issue_request(OP_GET, 32'h5555_5555, 6'd0);
        issue_request(OP_GET, 32'hAAAA_AAAA, 6'd63);
        issue_request(OP_RELEASE, 32'hFFFF_FFFF, 6'd3);
        issue_request(OP_RELEASE, 32'h0000_0000, 6'd4);
        issue_request(OP_GET, 32'hAAAA_AAAA, 6'd0);      // hit on newest entry
        issue_request(OP_GET, 32'h5555_5555, 6'd0);      // hit

        // Random episodes: mixed traffic, drain to empty, refill to full
        for (int ep = 0; ep < 4; ep++) begin
            quiet = (ep == 1);
            for (int n = 0; n < 180; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 40 && sb.next_unused > 0) begin
                    issue_request(OP_RELEASE, $urandom,
                                  BUF_W'($urandom_range(0, sb.next_unused - 1)));
                end else begin
                    pick = $urandom_range(0, 99);
                    if (pick < 45 && sb.next_unused > 0) begin
                        addr = sb.buffer_tag[$urandom_range(0, sb.next_unused - 1)];
                    end else if (pick < 52) begin
                        addr = pick[0] ? '1 : '0;
                    end else begin
                        addr = $urandom;
                    end
                    issue_request(OP_GET, addr, BUF_W'($urandom));
                end
            end

            // misses use up the pool, then evict until the used queue is empty
            while (sb.next_unused < POOL || sb.queued > 0) begin
                issue_request(OP_GET, $urandom, BUF_W'($urandom));
            end
            // nothing left to hand out
            repeat (3) issue_request(OP_GET, $urandom, BUF_W'($urandom));

            // release every buffer in shuffled order, then overflow the queue
            for (int j = 0; j < POOL; j++) begin
                order[j] = j;
            end
            for (int j = POOL - 1; j > 0; j--) begin
                k        = $urandom_range(0, j);
                t        = order[j];
                order[j] = order[k];
                order[k] = t;
            end
            for (int j = 0; j < POOL; j++) begin
                issue_request(OP_RELEASE, $urandom, BUF_W'(order[j]));
            end
            repeat (2) issue_request(OP_RELEASE, $urandom, BUF_W'($urandom));
        end
        quiet = 1'b0;

        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (sb.awaited_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (80) @(posedge i_clk);
        if (sb.awaited_results.size() != 0) begin
            sb.mismatches++;
        end

        $display("Sent %0d requests: %0d hits, %0d fresh, %0d evictions, %0d empty-pool misses",
                 issued, sb.status_seen[ST_HIT], sb.status_seen[ST_FRESH],
                 sb.status_seen[ST_EVICT], sb.status_seen[ST_NONE]);
        $display("Releases: %0d appended, %0d already queued or full; %0d mismatches",
                 sb.status_seen[ST_APPEND], sb.status_seen[ST_QUEUED], sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #1_000_000;
        $display("Timed out with %0d results outstanding", sb.awaited_results.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
